[hw/rtl/swmzf_pkg.sv]
// Shared constants for the strided window mean and zero fraction block.
// Used by the divider, the sample ring and the top level; depends on nothing.
package swmzf_pkg;

    localparam int unsigned SAMPLE_W       = 17;
    localparam int unsigned FRAC_BITS      = 16;
    localparam int unsigned WIN_W          = 9;
    localparam int unsigned STRIDE_W       = 13;
    localparam int unsigned COUNTDOWN_W    = 12;
    localparam int unsigned MAX_STRIDE     = 4096;
    localparam int unsigned DEF_MAX_WINDOW = 256;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 17;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_THRESHOLD = 2'd2;

    localparam logic [WIN_W-1:0]    RST_WINDOW_LENGTH  = 9'd16;
    localparam logic [STRIDE_W-1:0] RST_STRIDE         = 13'd4;
    localparam logic [SAMPLE_W-1:0] RST_ZERO_THRESHOLD = 17'd66;

    // Widths that follow from the ring depth.
    localparam int unsigned DEF_LEN_W  = $clog2(DEF_MAX_WINDOW + 1);
    localparam int unsigned DEF_DEND_W = SAMPLE_W + DEF_LEN_W;

endpackage

[hw/rtl/strided_window_mean_and_zero_fraction.sv]
// Strided window mean and zero fraction. Each accepted sample beat enters a ring of
// the last window_length samples and updates running sums; a full window result is
// produced every stride samples once the ring is full, and a beat marked final_sample
// also produces a tail window over the last min(window_length, N) samples, after
// which the stream starts afresh. A beat that produces no result passes through the
// IDLE and UPD states; each result then passes through LOAD, DIVM, DIVZ and PUT,
// using the one-bit-per-cycle divider that computes both the mean and the zero
// fraction in turn. Writing window_length or stride restarts the stream;
// zero_threshold applies to the samples that follow. A pending configuration write
// holds off the sample input for that cycle.
module strided_window_mean_and_zero_fraction #(
    parameter int unsigned MAX_WINDOW = swmzf_pkg::DEF_MAX_WINDOW
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [swmzf_pkg::SAMPLE_W-1:0]    i_mean_ratio_sample,
    input  logic [swmzf_pkg::SAMPLE_W-1:0]    i_damage_ratio_sample,
    input  logic                              i_final_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [swmzf_pkg::SAMPLE_W-1:0]    o_window_mean,
    output logic [swmzf_pkg::SAMPLE_W-1:0]    o_zero_fraction,
    output logic                              o_is_tail_window,
    output logic                              o_last_of_run,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swmzf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [swmzf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import swmzf_pkg::*;

    localparam int unsigned AW    = $clog2(MAX_WINDOW);
    localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int unsigned SUM_W = SAMPLE_W + LEN_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DIVM = 3'd3;
    localparam logic [2:0] S_DIVZ = 3'd4;
    localparam logic [2:0] S_PUT  = 3'd5;

    // Configuration registers.
    logic [WIN_W-1:0]    r_win_len;
    logic [STRIDE_W-1:0] r_stride;
    logic [SAMPLE_W-1:0] r_thresh;

    // Stream state.
    logic [SUM_W-1:0]       r_sum;
    logic [LEN_W-1:0]       r_zcnt;
    logic [LEN_W-1:0]       r_filled;
    logic [COUNTDOWN_W-1:0] r_cd;
    logic [AW-1:0]          r_pos;

    // Item in flight.
    logic [2:0]          r_state;
    logic [SAMPLE_W-1:0] r_mr;
    logic                r_z;
    logic                r_fin;
    logic                r_full;
    logic [AW-1:0]       r_p;
    logic                r_do_full;
    logic                r_do_tail;
    logic [SUM_W-1:0]    r_snap_sum;
    logic [LEN_W-1:0]    r_snap_zcnt;
    logic                r_job_tail;
    logic [LEN_W-1:0]    r_job_len;
    logic [LEN_W-1:0]    r_job_zcnt;
    logic [SAMPLE_W-1:0] r_mean;

    // Output register.
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_mean;
    logic [SAMPLE_W-1:0] r_out_zfrac;
    logic                r_out_tail;
    logic                r_out_last;

    logic [LEN_W-1:0]    eff_w;
    logic [STRIDE_W-1:0] eff_s;
    logic                in_acc;
    logic                out_acc;
    logic                cfg_acc;
    logic                clear_stream;
    logic [AW-1:0]       p;
    logic [LEN_W-1:0]    p_inc;
    logic                full_now;
    logic [SAMPLE_W:0]   rd_data;
    logic                div_start;
    logic [SUM_W-1:0]    div_dend;
    logic [LEN_W-1:0]    div_len;
    logic                div_done;
    logic [SAMPLE_W-1:0] div_quo;
    logic                put_ok;

    always_comb begin
        if (r_win_len == '0) begin
            eff_w = LEN_W'(1);
        end else if (32'(r_win_len) > MAX_WINDOW) begin
            eff_w = LEN_W'(MAX_WINDOW);
        end else begin
            eff_w = LEN_W'(r_win_len);
        end
        if (r_stride == '0) begin
            eff_s = STRIDE_W'(1);
        end else if (32'(r_stride) > MAX_STRIDE) begin
            eff_s = STRIDE_W'(MAX_STRIDE);
        end else begin
            eff_s = r_stride;
        end
    end

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_out_valid && !i_out_stall;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign full_now = r_filled >= eff_w;
    assign p        = (LEN_W'(r_pos) >= eff_w) ? '0 : r_pos;
    assign p_inc    = LEN_W'(r_p) + LEN_W'(1);
    assign put_ok   = !r_out_valid || !i_out_stall;

    assign clear_stream = (cfg_acc && (i_cfg_index == REG_WINDOW_LENGTH
                                       || i_cfg_index == REG_STRIDE))
                       || (r_state == S_PUT && put_ok && r_job_tail);

    swmzf_ring #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (p),
        .o_rd_data (rd_data),
        .i_wr_en   (r_state == S_UPD),
        .i_wr_addr (r_p),
        .i_wr_data ({r_z, r_mr})
    );

    swmzf_div #(
        .LEN_W  (LEN_W),
        .DEND_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dend),
        .i_divisor  (div_len),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // The mean is divided first, then the zero count scaled to Q1.16.
    always_comb begin
        div_start = 1'b0;
        div_dend  = {1'b0, r_job_zcnt, {FRAC_BITS{1'b0}}};
        div_len   = r_job_len;
        if (r_state == S_LOAD) begin
            div_start = 1'b1;
            div_dend  = r_do_full ? r_snap_sum : r_sum;
            div_len   = r_do_full ? eff_w : r_filled;
        end else if (r_state == S_DIVM && div_done) begin
            div_start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= RST_WINDOW_LENGTH;
            r_stride    <= RST_STRIDE;
            r_thresh    <= RST_ZERO_THRESHOLD;
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_zcnt      <= '0;
            r_filled    <= '0;
            r_cd        <= '0;
            r_pos       <= '0;
            r_do_full   <= 1'b0;
            r_do_tail   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    REG_WINDOW_LENGTH:  r_win_len <= i_cfg_data[WIN_W-1:0];
                    REG_STRIDE:         r_stride  <= i_cfg_data[STRIDE_W-1:0];
                    REG_ZERO_THRESHOLD: r_thresh  <= i_cfg_data[SAMPLE_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_do_full <= full_now && (r_cd == '0);
                        if (full_now) begin
                            if (r_cd == '0) begin
                                r_cd <= COUNTDOWN_W'(eff_s - STRIDE_W'(1));
                            end else begin
                                r_cd <= r_cd - COUNTDOWN_W'(1);
                            end
                        end
                        r_do_tail <= i_final_sample;
                        r_state   <= S_UPD;
                    end
                end
                S_UPD: begin
                    // Retire the oldest sample once the ring holds a whole window.
                    if (r_full) begin
                        r_sum  <= r_sum - SUM_W'(rd_data[SAMPLE_W-1:0]) + SUM_W'(r_mr);
                        r_zcnt <= r_zcnt - LEN_W'(rd_data[SAMPLE_W]) + LEN_W'(r_z);
                    end else begin
                        r_sum    <= r_sum + SUM_W'(r_mr);
                        r_zcnt   <= r_zcnt + LEN_W'(r_z);
                        r_filled <= r_filled + LEN_W'(1);
                    end
                    r_pos   <= (p_inc >= eff_w) ? '0 : AW'(p_inc);
                    r_state <= (r_do_full || r_do_tail) ? S_LOAD : S_IDLE;
                end
                S_LOAD: begin
                    r_state <= S_DIVM;
                end
                S_DIVM: begin
                    if (div_done) begin
                        r_state <= S_DIVZ;
                    end
                end
                S_DIVZ: begin
                    if (div_done) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (put_ok) begin
                        if (r_job_tail) begin
                            r_do_tail <= 1'b0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_do_full <= 1'b0;
                            r_state   <= r_do_tail ? S_LOAD : S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (r_state == S_PUT && put_ok) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end

            if (clear_stream) begin
                r_sum    <= '0;
                r_zcnt   <= '0;
                r_filled <= '0;
                r_cd     <= '0;
                r_pos    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mr        <= i_mean_ratio_sample;
            r_z         <= i_damage_ratio_sample < r_thresh;
            r_fin       <= i_final_sample;
            r_full      <= full_now;
            r_p         <= p;
            r_snap_sum  <= r_sum;
            r_snap_zcnt <= r_zcnt;
        end
        if (r_state == S_LOAD) begin
            r_job_tail <= !r_do_full;
            r_job_len  <= r_do_full ? eff_w : r_filled;
            r_job_zcnt <= r_do_full ? r_snap_zcnt : r_zcnt;
        end
        if (r_state == S_DIVM && div_done) begin
            r_mean <= div_quo;
        end
        if (r_state == S_PUT && put_ok) begin
            r_out_mean  <= r_mean;
            r_out_zfrac <= div_quo;
            r_out_tail  <= r_job_tail;
            r_out_last  <= r_job_tail || !r_do_tail;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready      = r_state == S_IDLE;
    assign o_out_valid      = r_out_valid;
    assign o_window_mean    = r_out_mean;
    assign o_zero_fraction  = r_out_zfrac;
    assign o_is_tail_window = r_out_tail;
    assign o_last_of_run    = r_out_last;

`ifndef SYNTHESIS
    a_filled_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= eff_w)
        else $error("fill count exceeds the window length");

    a_tail_needs_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && put_ok && r_job_tail) |-> r_fin)
        else $error("tail window without a final sample");

    a_put_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && put_ok) |=> o_out_valid)
        else $error("result not presented after it was finished");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVM || r_state == S_DIVZ))
        else $error("divider finished outside a division step");
`endif

endmodule

[hw/rtl/swmzf_div.sv]
// Restoring divider, one quotient bit per cycle, shared by both window figures.
// Depends on swmzf_pkg for the sample width.
module swmzf_div #(
    parameter int unsigned LEN_W  = swmzf_pkg::DEF_LEN_W,
    parameter int unsigned DEND_W = swmzf_pkg::DEF_DEND_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DEND_W-1:0]             i_dividend,
    input  logic [LEN_W-1:0]              i_divisor,
    output logic                          o_done,
    output logic [swmzf_pkg::SAMPLE_W-1:0] o_quotient
);
    import swmzf_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEND_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DEND_W-1:0]   r_dend;
    logic [LEN_W-1:0]    r_div;
    logic [LEN_W-1:0]    r_rem;
    logic [SAMPLE_W-1:0] r_quo;

    logic [LEN_W:0] trial;
    logic           ge;

    assign trial = {r_rem, r_dend[DEND_W-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient always fits 17 bits here, so higher quotient bits are dropped.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dend <= i_dividend;
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_dend <= {r_dend[DEND_W-2:0], 1'b0};
            r_rem  <= ge ? LEN_W'(trial - {1'b0, r_div}) : trial[LEN_W-1:0];
            r_quo  <= {r_quo[SAMPLE_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hw/rtl/swmzf_ring.sv]
// Sample ring: ratio sample and zero flag per entry, one write and one read port.
// Depends on swmzf_pkg for the sample width.
module swmzf_ring #(
    parameter int unsigned MAX_WINDOW = swmzf_pkg::DEF_MAX_WINDOW
) (
    input  logic                            i_clk,
    input  logic                            i_rd_en,
    input  logic [$clog2(MAX_WINDOW)-1:0]   i_rd_addr,
    output logic [swmzf_pkg::SAMPLE_W:0]    o_rd_data,
    input  logic                            i_wr_en,
    input  logic [$clog2(MAX_WINDOW)-1:0]   i_wr_addr,
    input  logic [swmzf_pkg::SAMPLE_W:0]    i_wr_data
);
    import swmzf_pkg::*;

    logic [SAMPLE_W:0] mem [MAX_WINDOW];
    logic [SAMPLE_W:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
